// ----- rtl/pdr_pkg.sv -----
// shared types, constants and codes of the difficulty retarget block
package pdr_pkg;

  localparam int DATA_W = 64;
  localparam int WIN_W = 8;
  localparam int GOAL_W = 32;
  localparam int EXP_W = WIN_W + GOAL_W;
  localparam int SPAN_W = EXP_W + 2;
  localparam int PROD_W = DATA_W + SPAN_W;
  localparam int HALF_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_WINDOW_DEF = 256;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam logic [WIN_W-1:0] WINDOW_RST = '0;
  localparam logic [GOAL_W-1:0] GOAL_RST = GOAL_W'(60);
  localparam logic [DATA_W-1:0] FLOOR_RST = '0;
  localparam logic [DATA_W-1:0] CEIL_RST = '1;
  localparam logic [DATA_W-1:0] START_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 3'd0,
    CFG_GOAL   = 3'd1,
    CFG_FLOOR  = 3'd2,
    CFG_CEIL   = 3'd3,
    CFG_START  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [WIN_W-1:0]  window;
    logic [GOAL_W-1:0] goal;
    logic [DATA_W-1:0] tgt_floor;
    logic [DATA_W-1:0] tgt_ceil;
    logic [DATA_W-1:0] tgt_start;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_WORK = 2'd0,
    DIV_MOD  = 2'd1,
    DIV_QUOT = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    TGT_BOUND = 2'd0,
    TGT_OVF   = 2'd1,
    TGT_QUOT  = 2'd2
  } tgt_src_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     work_upd;
    logic     ring_rd;
    logic     span_ld;
    logic     mul_step;
    logic     tgt_upd;
    tgt_src_t tgt_src;
    logic     out_load;
  } pdr_cmd_t;

  typedef struct packed {
    logic restart;
    logic pre_ok;
    logic div_done;
    logic rem_zero;
    logic mul_last;
    logic ovf;
  } pdr_sts_t;

endpackage

// ----- rtl/pdr_in_if.sv -----
// input channel: restart or block-accepted transactions
interface pdr_in_if import pdr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              action;
  logic [DATA_W-1:0] block_time;

  modport source (output valid, action, block_time, input ready);
  modport sink (input valid, action, block_time, output ready);
endinterface

// ----- rtl/pdr_out_if.sv -----
// result channel: next target, work tally and height
interface pdr_out_if import pdr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] next_target;
  logic [DATA_W-1:0] total_work;
  logic              retargeted;
  logic [DATA_W-1:0] chain_height;

  modport source (output valid, next_target, total_work, retargeted, chain_height,
                  input ready);
  modport sink (input valid, next_target, total_work, retargeted, chain_height,
                output ready);
endinterface

// ----- rtl/pdr_cfg_if.sv -----
// configuration write channel
interface pdr_cfg_if import pdr_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pdr_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module pdr_divider import pdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DATA_W) + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // subtract when the shifted remainder covers the divisor
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/pdr_datapath.sv -----
// chain state, timestamp ring, span logic, multiplier and shared divider
module pdr_datapath import pdr_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  pdr_cmd_t          cmd,
  output pdr_sts_t          sts,
  input  logic              in_action,
  input  logic [DATA_W-1:0] in_block_time,
  output logic [DATA_W-1:0] out_next_target,
  output logic [DATA_W-1:0] out_total_work,
  output logic              out_retargeted,
  output logic [DATA_W-1:0] out_chain_height
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int IDX_W = ((SLOT_W > WIN_W) ? SLOT_W : WIN_W) + 1;

  function automatic logic [DATA_W-1:0] bound_target(
    input logic [DATA_W-1:0] t,
    input logic [DATA_W-1:0] lo,
    input logic [DATA_W-1:0] hi
  );
    logic [DATA_W-1:0] r;
    if (t < lo) r = lo;
    else if (t > hi) r = hi;
    else r = t;
    return r;
  endfunction

  // control state
  logic [DATA_W-1:0] height_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DATA_W-1:0] target_r;
  logic [DATA_W-1:0] work_r;

  // per-transaction payload
  logic              action_r;
  logic [DATA_W-1:0] btime_r;
  logic [EXP_W-1:0]  expected_r;
  logic [DATA_W-1:0] old_time_r;
  logic [SPAN_W-1:0] span_r;
  logic [PROD_W-1:0] acc_r;
  logic [1:0]        mul_cnt_r;
  logic              retgt_r;
  logic [DATA_W-1:0] out_target_r;
  logic [DATA_W-1:0] out_work_r;
  logic              out_retgt_r;
  logic [DATA_W-1:0] out_height_r;

  logic [DATA_W-1:0] ring_mem [MAX_WINDOW];

  logic [WIN_W-1:0]  win_eff;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SLOT_W-1:0] wr_slot;
  logic [IDX_W-1:0]  slot_diff;
  logic [SLOT_W-1:0] old_slot;
  logic [DATA_W-1:0] height_nxt;

  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] work_inc;

  logic [DATA_W-1:0] observed;
  logic [DATA_W-1:0] low_span;
  logic [DATA_W-1:0] high_span;
  logic [DATA_W-1:0] span_lo;
  logic [DATA_W-1:0] span_v;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [DATA_W-1:0] pp;
  logic [6:0]        pp_sh;
  logic [DATA_W-1:0] tgt_new;

  // a window at or above the ring depth saturates so the bound stays in the ring
  assign win_eff = (32'(cfg.window) >= 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW - 1) : cfg.window;

  assign slot_inc = (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
  assign slot_nxt = (height_r == ALL_ONES) ? '0 : slot_inc;
  assign wr_slot  = in_action ? slot_nxt : '0;
  assign height_nxt = in_action ? height_r + 1'b1 : '0;

  // oldest bound: block at height - window, block 1 when that is genesis
  assign slot_diff = IDX_W'(slot_r) - IDX_W'(win_eff);
  always_comb begin
    if (height_r == DATA_W'(win_eff)) old_slot = SLOT_W'(1);
    else if (slot_diff[IDX_W-1]) old_slot = SLOT_W'(slot_diff + IDX_W'(MAX_WINDOW));
    else old_slot = SLOT_W'(slot_diff);
  end

  // divider operand selection
  always_comb begin
    case (cmd.div_sel)
      DIV_MOD: begin
        div_dividend = height_r;
        div_divisor  = DATA_W'(win_eff);
      end
      DIV_QUOT: begin
        div_dividend = acc_r[DATA_W-1:0];
        div_divisor  = DATA_W'(expected_r);
      end
      default: begin
        div_dividend = ALL_ONES;
        div_divisor  = target_r;
      end
    endcase
  end
  assign div_start = cmd.div_start;

  pdr_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign work_inc = (target_r == '0) ? ALL_ONES : div_quo;

  // observed span, capped to the expected range
  always_comb begin
    observed  = (btime_r > old_time_r) ? btime_r - old_time_r : DATA_W'(1);
    low_span  = (expected_r[EXP_W-1:2] == '0) ? DATA_W'(1) : DATA_W'(expected_r[EXP_W-1:2]);
    high_span = DATA_W'({expected_r, 2'b00});
    span_lo   = (observed < low_span) ? low_span : observed;
    span_v    = (span_lo > high_span) ? high_span : span_lo;
  end

  // 32x32 partial products, one per cycle
  always_comb begin
    case (mul_cnt_r)
      2'd0: begin
        mul_a = target_r[HALF_W-1:0];
        mul_b = span_r[HALF_W-1:0];
        pp_sh = 7'd0;
      end
      2'd1: begin
        mul_a = target_r[HALF_W-1:0];
        mul_b = HALF_W'(span_r[SPAN_W-1:HALF_W]);
        pp_sh = 7'(HALF_W);
      end
      2'd2: begin
        mul_a = target_r[DATA_W-1:HALF_W];
        mul_b = span_r[HALF_W-1:0];
        pp_sh = 7'(HALF_W);
      end
      default: begin
        mul_a = target_r[DATA_W-1:HALF_W];
        mul_b = HALF_W'(span_r[SPAN_W-1:HALF_W]);
        pp_sh = 7'(DATA_W);
      end
    endcase
  end
  assign pp = DATA_W'(mul_a) * DATA_W'(mul_b);

  always_comb begin
    case (cmd.tgt_src)
      TGT_OVF:  tgt_new = bound_target(cfg.tgt_ceil, cfg.tgt_floor, cfg.tgt_ceil);
      TGT_QUOT: tgt_new = bound_target(div_quo, cfg.tgt_floor, cfg.tgt_ceil);
      default:  tgt_new = bound_target(target_r, cfg.tgt_floor, cfg.tgt_ceil);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= '0;
      slot_r   <= '0;
      target_r <= START_RST;
      work_r   <= '0;
    end else begin
      if (cmd.load) begin
        height_r <= height_nxt;
        slot_r   <= wr_slot;
        if (!in_action) target_r <= cfg.tgt_start;
      end else if (cmd.tgt_upd) begin
        target_r <= tgt_new;
      end
      if (cmd.work_upd) work_r <= action_r ? work_r + work_inc : work_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) ring_mem[wr_slot] <= in_block_time;
    if (cmd.ring_rd) old_time_r <= ring_mem[old_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= in_action;
      btime_r    <= in_block_time;
      expected_r <= EXP_W'(win_eff) * EXP_W'(cfg.goal);
      retgt_r    <= 1'b0;
    end
    if (cmd.span_ld) begin
      span_r    <= span_v[SPAN_W-1:0];
      acc_r     <= '0;
      mul_cnt_r <= '0;
      retgt_r   <= 1'b1;
    end else if (cmd.mul_step) begin
      acc_r     <= acc_r + (PROD_W'(pp) << pp_sh);
      mul_cnt_r <= mul_cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_target_r <= target_r;
      out_work_r   <= work_r;
      out_retgt_r  <= retgt_r;
      out_height_r <= height_r;
    end
  end

  always_comb begin
    sts.restart  = !action_r;
    sts.pre_ok   = (win_eff != '0) && (height_r >= DATA_W'(win_eff)) &&
                   (expected_r != '0) && (height_r != DATA_W'(1));
    sts.div_done = div_done;
    sts.rem_zero = (div_rem == '0);
    sts.mul_last = (mul_cnt_r == 2'd3);
    sts.ovf      = (acc_r[PROD_W-1:DATA_W] != '0);
  end

  assign out_next_target  = out_target_r;
  assign out_total_work   = out_work_r;
  assign out_retargeted   = out_retgt_r;
  assign out_chain_height = out_height_r;

endmodule

// ----- rtl/pdr_ctrl.sv -----
// sequencing state machine and result valid
module pdr_ctrl import pdr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pdr_sts_t sts,
  output pdr_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WGO    = 9'b000000010,
    S_WWAIT  = 9'b000000100,
    S_MWAIT  = 9'b000001000,
    S_SPAN   = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_MCHK   = 9'b001000000,
    S_QWAIT  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = DIV_WORK;
    cmd.tgt_src   = TGT_BOUND;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WGO;
        end
      end
      S_WGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WORK;
        state_nxt     = S_WWAIT;
      end
      S_WWAIT: begin
        if (sts.div_done) begin
          cmd.work_upd = 1'b1;
          if (sts.restart) begin
            state_nxt = S_FINISH;
          end else if (!sts.pre_ok) begin
            cmd.tgt_upd = 1'b1;
            cmd.tgt_src = TGT_BOUND;
            state_nxt   = S_FINISH;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MOD;
            state_nxt     = S_MWAIT;
          end
        end
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          // height not on a window boundary
          if (!sts.rem_zero) begin
            cmd.tgt_upd = 1'b1;
            cmd.tgt_src = TGT_BOUND;
            state_nxt   = S_FINISH;
          end else begin
            cmd.ring_rd = 1'b1;
            state_nxt   = S_SPAN;
          end
        end
      end
      S_SPAN: begin
        cmd.span_ld = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (sts.ovf) begin
          cmd.tgt_upd = 1'b1;
          cmd.tgt_src = TGT_OVF;
          state_nxt   = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_QUOT;
          state_nxt     = S_QWAIT;
        end
      end
      S_QWAIT: begin
        cmd.div_sel = DIV_QUOT;
        if (sts.div_done) begin
          cmd.tgt_upd = 1'b1;
          cmd.tgt_src = TGT_QUOT;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/pow_difficulty_retarget.sv -----
// top level: configuration registers, controller and datapath
//
// Proof-of-work difficulty retarget and cumulative work tally.
// in_ch carries one transaction per chain event: action 0 restarts the chain
// at genesis with block_time as the genesis timestamp, action 1 appends a
// block. Every input transaction yields exactly one out_ch transaction with
// the next target, the cumulative work, the retarget flag and the height.
// cfg_ch writes the five configuration registers by index, one per cycle;
// it is always ready and must only be written while the block is idle; the block does not enforce this.
// A restart or a block that cannot be a boundary (window off, height below it or at
// one, or zero goal) uses only the work division; checking the height remainder
// adds a second, and a window retarget adds the multiply and the scaled target
// division, which product overflow skips. Each 64-bit division (work, height
// remainder, scaled target) runs on the single shared bit-serial divider; the
// multiply sums 32x32 partial products. One transaction at a time, the next
// taken in the cycle after a result loads; in_ch is ready whenever the sequencer
// is idle, also while a finished result waits in the output register. A stalled
// receiver holds the result there and the next result waits in its final state
// until the register is free. Reset clears height and work, loads the default
// configuration and sets the target to all ones; the timestamp ring is not cleared.
module pow_difficulty_retarget import pdr_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pdr_in_if.sink        in_ch,
  pdr_out_if.source     out_ch,
  pdr_cfg_if.sink       cfg_ch
);

  cfg_t     cfg_r, cfg_nxt;
  pdr_cmd_t cmd;
  pdr_sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_WINDOW: cfg_nxt.window    = cfg_ch.data[WIN_W-1:0];
        CFG_GOAL:   cfg_nxt.goal      = cfg_ch.data[GOAL_W-1:0];
        CFG_FLOOR:  cfg_nxt.tgt_floor = cfg_ch.data;
        CFG_CEIL:   cfg_nxt.tgt_ceil  = cfg_ch.data;
        CFG_START:  cfg_nxt.tgt_start = cfg_ch.data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window    <= WINDOW_RST;
      cfg_r.goal      <= GOAL_RST;
      cfg_r.tgt_floor <= FLOOR_RST;
      cfg_r.tgt_ceil  <= CEIL_RST;
      cfg_r.tgt_start <= START_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  pdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdr_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_block_time    (in_ch.block_time),
    .out_next_target  (out_ch.next_target),
    .out_total_work   (out_ch.total_work),
    .out_retargeted   (out_ch.retargeted),
    .out_chain_height (out_ch.chain_height)
  );

endmodule

// ----- dv/pow_difficulty_retarget_tb.sv -----
`timescale 1ns / 1ps
// testbench of the difficulty retarget block: directed chains, random chains, scoreboard
module pow_difficulty_retarget_tb;
  import pdr_pkg::*;

  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_BLOCK   = 1'b1;
  localparam int RING_DEPTH  = MAX_WINDOW_DEF;
  localparam int IDLE_PCT    = 27;
  localparam int HOLD_CYCLES = 500;
  localparam int STALL_LIMIT = 3000;
  localparam int END_PAUSE   = 300;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [DATA_W-1:0] next_target;
    logic [DATA_W-1:0] total_work;
    logic              retargeted;
    logic [DATA_W-1:0] chain_height;
  } chain_result_t;

  logic clk;
  logic rst_n;

  pdr_in_if  in_ch ();
  pdr_out_if out_ch ();
  pdr_cfg_if cfg_ch ();

  pow_difficulty_retarget dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // configuration mirror, starts at the reset values
  logic [WIN_W-1:0]  r_window = WINDOW_RST;
  logic [GOAL_W-1:0] r_goal   = GOAL_RST;
  logic [DATA_W-1:0] r_floor  = FLOOR_RST;
  logic [DATA_W-1:0] r_ceil   = CEIL_RST;
  logic [DATA_W-1:0] r_start  = START_RST;

  // chain state of the predictor
  logic [DATA_W-1:0] chain_height = '0;
  logic [DATA_W-1:0] chain_work   = '0;
  logic [DATA_W-1:0] chain_target = ALL_ONES;
  logic [DATA_W-1:0] stamp_ring [RING_DEPTH];

  chain_result_t pending_results [$];

  int err_count   = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_restarts  = 0;
  int n_retargets = 0;
  int stall_cycles = 0;
  bit tx_idle  = 1'b1;
  bit rx_idle  = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] work_of(logic [DATA_W-1:0] t);
    return (t == '0) ? ALL_ONES : ALL_ONES / t;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_target(logic [DATA_W-1:0] t);
    if (t < r_floor) return r_floor;
    if (t > r_ceil) return r_ceil;
    return t;
  endfunction

  // window rescale of the target; the 8-bit window never reaches the ring depth
  function automatic logic [DATA_W-1:0] rescale_target(output logic did);
    logic [DATA_W-1:0] win, h, oldest, t_new, t_old, observed, expected, lo, hi, span;
    did = 1'b0;
    win = DATA_W'(r_window);
    h = chain_height;
    if (win == '0 || h < win) return clamp_target(chain_target);
    if ((h % win) != '0) return clamp_target(chain_target);
    oldest = h - win;
    if (oldest == '0) oldest = 64'd1;
    if (oldest >= h) return clamp_target(chain_target);
    expected = win * DATA_W'(r_goal);
    if (expected == '0) return clamp_target(chain_target);
    t_new = stamp_ring[h % RING_DEPTH];
    t_old = stamp_ring[oldest % RING_DEPTH];
    observed = (t_new > t_old) ? t_new - t_old : 64'd1;
    lo = expected / 4;
    if (lo < 64'd1) lo = 64'd1;
    hi = expected * 4;
    span = observed;
    if (span < lo) span = lo;
    if (span > hi) span = hi;
    did = 1'b1;
    if (chain_target > ALL_ONES / span) return clamp_target(r_ceil);
    return clamp_target((chain_target * span) / expected);
  endfunction

  function automatic chain_result_t advance_chain(logic act, logic [DATA_W-1:0] bt);
    chain_result_t r;
    logic did;
    did = 1'b0;
    if (act == ACT_RESTART) begin
      chain_height = '0;
      chain_target = r_start;
      chain_work = work_of(chain_target);
      stamp_ring[0] = bt;
    end else begin
      chain_height = chain_height + 64'd1;
      stamp_ring[chain_height % RING_DEPTH] = bt;
      chain_work = chain_work + work_of(chain_target);
      chain_target = rescale_target(did);
    end
    r.next_target = chain_target;
    r.total_work = chain_work;
    r.retargeted = did;
    r.chain_height = chain_height;
    return r;
  endfunction

  task automatic log_mismatch(string what, logic [DATA_W-1:0] got_v, logic [DATA_W-1:0] want_v);
    if (err_count < MAX_REPORTS)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got_v, want_v);
    err_count++;
  endtask

  // scoreboard: result check first, then prediction of the accepted transaction
  always @(posedge clk) begin
    chain_result_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.next_target = out_ch.next_target;
        got.total_work = out_ch.total_work;
        got.retargeted = out_ch.retargeted;
        got.chain_height = out_ch.chain_height;
        n_results++;
        if (pending_results.size() == 0) begin
          log_mismatch("result with nothing pending", got.next_target, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.next_target !== want.next_target)
            log_mismatch("next_target", got.next_target, want.next_target);
          if (got.total_work !== want.total_work)
            log_mismatch("total_work", got.total_work, want.total_work);
          if (got.retargeted !== want.retargeted)
            log_mismatch("retargeted", 64'(got.retargeted), 64'(want.retargeted));
          if (got.chain_height !== want.chain_height)
            log_mismatch("chain_height", got.chain_height, want.chain_height);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = advance_chain(in_ch.action, in_ch.block_time);
        pending_results.insert(pending_results.size(), want);
        n_items++;
        if (in_ch.action == ACT_RESTART) n_restarts++;
        if (want.retargeted) n_retargets++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_WINDOW: r_window = cfg_ch.data[WIN_W-1:0];
          CFG_GOAL:   r_goal = cfg_ch.data[GOAL_W-1:0];
          CFG_FLOOR:  r_floor = cfg_ch.data;
          CFG_CEIL:   r_ceil = cfg_ch.data;
          CFG_START:  r_start = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (rx_idle) begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DATA_W-1:0] rand_target();
    case ($urandom_range(5))
      0: return ALL_ONES;
      1: return rand_word();
      2: return 64'($urandom_range(1 << 20));
      3: return {32'd0, $urandom} << $urandom_range(24);
      4: return 64'($urandom_range(3));
      default: return rand_word() >> $urandom_range(40);
    endcase
  endfunction

  // pace 0 keeps near the goal, 1 runs fast, 2 runs slow
  function automatic logic [DATA_W-1:0] next_stamp(logic [DATA_W-1:0] prev, int pace);
    logic [DATA_W-1:0] g;
    int pick;
    g = (r_goal == '0) ? 64'd1 : DATA_W'(r_goal);
    pick = $urandom_range(99);
    if (pick < 8) return prev - 64'($urandom_range(5));
    if (pick < 16) return prev + 64'($urandom_range(3));
    if (pick < 92) begin
      case (pace)
        1: return prev + (g * 64'($urandom_range(20))) / 100;
        2: return prev + (g * 64'($urandom_range(800, 300))) / 100;
        default: return prev + g / 2 + (g * 64'($urandom_range(150))) / 100;
      endcase
    end
    return prev + {24'd0, $urandom, 8'($urandom_range(255))};
  endfunction

  task automatic send_item(logic act, logic [DATA_W-1:0] bt);
    @(negedge clk);
    if (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(20, 1)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.block_time <= bt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_cfg(logic [WIN_W-1:0] win, logic [GOAL_W-1:0] goal,
                             logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                             logic [DATA_W-1:0] st);
    wait_drain();
    cfg_write(CFG_WINDOW, DATA_W'(win));
    cfg_write(CFG_GOAL, DATA_W'(goal));
    cfg_write(CFG_FLOOR, lo);
    cfg_write(CFG_CEIL, hi);
    cfg_write(CFG_START, st);
  endtask

  task automatic pick_cfg();
    logic [WIN_W-1:0]  win;
    logic [GOAL_W-1:0] goal;
    logic [DATA_W-1:0] lo, hi;
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) win = WIN_W'($urandom_range(4, 1));
    else if (pick < 7) win = WIN_W'($urandom_range(16, 2));
    else if (pick < 8) win = '0;
    else win = WIN_W'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 5) goal = GOAL_W'($urandom_range(600, 1));
    else if (pick < 7) goal = GOAL_W'($urandom_range(3));
    else if (pick < 8) goal = '1;
    else goal = $urandom;
    case ($urandom_range(3))
      0: begin lo = '0; hi = ALL_ONES; end
      1: begin lo = 64'($urandom_range(1 << 16)); hi = ALL_ONES >> $urandom_range(30); end
      2: begin lo = rand_word() >> $urandom_range(63); hi = rand_word() >> $urandom_range(63); end
      default: begin lo = '0; hi = rand_word(); end
    endcase
    program_cfg(win, goal, lo, hi, rand_target());
  endtask

  // well-formed chains with random content, mixed with random transactions
  task automatic run_chain_traffic(int n_send, int len_lo, int len_hi, int noise_pct);
    logic [DATA_W-1:0] stamp;
    int left, pace;
    left = 0;
    pace = 0;
    stamp = '0;
    for (int sent = 0; sent < n_send; sent++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_item(1'($urandom_range(1)), rand_word());
      end else if (left == 0) begin
        stamp = rand_word() >> $urandom_range(63, 8);
        left = $urandom_range(len_hi, len_lo);
        pace = $urandom_range(2);
        send_item(ACT_RESTART, stamp);
      end else begin
        stamp = next_stamp(stamp, pace);
        send_item(ACT_BLOCK, stamp);
        left--;
      end
    end
  endtask

  // a block straight after reset, then a restart at the default start target
  task automatic test_reset_state();
    send_item(ACT_BLOCK, 64'd100);
    send_item(ACT_RESTART, '0);
  endtask

  // zero target counts as all-ones work, the tally wraps
  task automatic test_zero_target();
    program_cfg(8'd0, 32'd60, '0, ALL_ONES, '0);
    send_item(ACT_RESTART, ALL_ONES);
    send_item(ACT_BLOCK, '0);
    send_item(ACT_BLOCK, 64'd7);
  endtask

  // window of one: first block is its own bound, then equal and capped spans
  task automatic test_single_window();
    program_cfg(8'd1, 32'd1, '0, ALL_ONES, 64'd1000);
    send_item(ACT_RESTART, '0);
    send_item(ACT_BLOCK, 64'd10);
    send_item(ACT_BLOCK, 64'd10);
    send_item(ACT_BLOCK, 64'd100);
  endtask

  task automatic test_zero_goal();
    program_cfg(8'd2, 32'd0, '0, ALL_ONES, 64'd12345);
    send_item(ACT_RESTART, 64'd50);
    send_item(ACT_BLOCK, 64'd60);
    send_item(ACT_BLOCK, 64'd70);
  endtask

  // long span on a big target overflows the product
  task automatic test_overflow();
    program_cfg(8'd2, 32'd60, '0, ALL_ONES, ALL_ONES >> 1);
    send_item(ACT_RESTART, '0);
    send_item(ACT_BLOCK, 64'd1000);
    send_item(ACT_BLOCK, 64'd2000000);
  endtask

  // floor above ceiling, and an unclamped start target on restart
  task automatic test_crossed_bounds();
    program_cfg(8'd2, 32'd60, 64'd5000, 64'd100, 64'd50);
    send_item(ACT_RESTART, '0);
    send_item(ACT_BLOCK, 64'd60);
    send_item(ACT_BLOCK, 64'd120);
  endtask

  task automatic test_max_goal();
    program_cfg(8'd3, '1, '0, ALL_ONES, 64'd1 << 40);
    send_item(ACT_RESTART, '0);
    send_item(ACT_BLOCK, 64'd1 << 33);
    send_item(ACT_BLOCK, 64'd1 << 34);
    send_item(ACT_BLOCK, 64'd1 << 36);
  endtask

  // receiver holds off while items keep coming, then the sender waits for all
  task automatic test_backpressure();
    program_cfg(8'd2, 32'd60, '0, ALL_ONES, 64'd1 << 30);
    tx_idle = 1'b0;
    hold_req = 1'b1;
    send_item(ACT_RESTART, 64'd1000);
    for (int i = 1; i <= 6; i++) send_item(ACT_BLOCK, 64'd1000 + 64'(i * 45));
    wait_drain();
    tx_idle = 1'b1;
  endtask

  task automatic test_steady_stream();
    program_cfg(8'd4, 32'd60, '0, ALL_ONES, 64'd1 << 40);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_chain_traffic(200, 4, 40, 5);
    wait_drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_wide_window();
    program_cfg(8'd255, '1, '0, ALL_ONES, rand_word() >> 8);
    run_chain_traffic(265, 262, 262, 0);
  endtask

  task automatic test_mixed_settings();
    for (int phase = 0; phase < 6; phase++) begin
      pick_cfg();
      run_chain_traffic(130, 2, 40, 8);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_RESTART;
    in_ch.block_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WINDOW;
    cfg_ch.data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_zero_target();
    test_single_window();
    test_zero_goal();
    test_overflow();
    test_crossed_bounds();
    test_max_goal();
    test_backpressure();
    test_steady_stream();
    test_wide_window();
    test_mixed_settings();

    wait_drain();
    repeat (END_PAUSE) @(posedge clk);
    if (pending_results.size() != 0)
      log_mismatch("results never arrived", 64'(pending_results.size()), '0);

    $display("covered %0d input transactions (%0d restarts) and %0d results",
             n_items, n_restarts, n_results);
    $display("window retargets applied: %0d, mismatches: %0d", n_retargets, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
